### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/swrca_pkg.sv
// ----------------------------------------------------------------------------
// swrca_pkg
// Widths, defaults and the result type of the sliding-window receiver.
// ----------------------------------------------------------------------------
package swrca_pkg;

  localparam int SEQ_W       = 31;
  localparam int ACK_W       = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int WINDOW_DEF  = 32;
  localparam logic [SEQ_W-1:0] TOTAL_RESET = 31'd20000;

  typedef struct packed {
    logic              all_received;
    logic [ACK_W-1:0]  ack_number;
  } result_t;

endpackage

### design/sliding_window_receiver_cumulative_ack_unit.sv
// An accepted sequence number waits in the input register until the result register
// can take it, then its result word is loaded there and offered. Throughput: one word per
// cycle unless the output stalls; the window advance is a single find-first-clear
// over the bitmap followed by a rotate, done between the input and result registers.
// Reset (synchronous, active high) clears the expected number and the bitmap, sets
// the total count to 20000 and empties both registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// sliding_window_receiver_cumulative_ack_unit
// Receiver side of a sliding-window transfer returning cumulative acks.
// ----------------------------------------------------------------------------
module sliding_window_receiver_cumulative_ack_unit #(
  parameter int WINDOW = swrca_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [swrca_pkg::SEQ_W-1:0]       cfg_wr_data,  // total_count
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [swrca_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [30:0] seq_number
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [swrca_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [31:0] ack_number,
                                                           // [32] all_received
);

  localparam int SW = swrca_pkg::SEQ_W;

  logic               held_valid;
  logic [SW-1:0]      held_seq;
  logic               can_load;
  logic               advance;
  swrca_pkg::result_t result;

  assign advance = held_valid && can_load;

  swrca_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_seq     (s_axis_tdata[SW-1:0]),
    .advance    (advance),
    .held_valid (held_valid),
    .held_seq   (held_seq)
  );

  swrca_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (advance),
    .item_seq    (held_seq),
    .result      (result)
  );

  swrca_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .can_load  (can_load),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

### design/swrca_in_reg.sv
// ----------------------------------------------------------------------------
// swrca_in_reg
// Input register for arriving sequence numbers.
// ----------------------------------------------------------------------------
module swrca_in_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swrca_pkg::SEQ_W-1:0] in_seq,
  input  logic                        advance,
  output logic                        held_valid,
  output logic [swrca_pkg::SEQ_W-1:0] held_seq
);

  // The register frees up in the same cycle its word moves on.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_seq <= in_seq;
    end
  end

endmodule

### design/swrca_window.sv
// ----------------------------------------------------------------------------
// swrca_window
// Expected sequence number, receive bitmap and total count register.
// ----------------------------------------------------------------------------
module swrca_window #(
  parameter int WINDOW = swrca_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [swrca_pkg::SEQ_W-1:0] cfg_wr_data,
  input  logic                        item_valid,
  input  logic [swrca_pkg::SEQ_W-1:0] item_seq,
  output swrca_pkg::result_t          result
);

  localparam int SW    = swrca_pkg::SEQ_W;
  localparam int AW    = swrca_pkg::ACK_W;
  localparam int D_W   = $clog2(WINDOW + 2);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Bit i of the map stands for the slot of sequence number expected + i,
  // counted around the window, so an advance rotates the map. Bit 0 can hold
  // a mark that was left behind when a lowered total stopped an advance; it
  // then belongs to the number one full window ahead.
  logic [SW-1:0]     expected;
  logic [SW-1:0]     expected_next;
  logic [WINDOW-1:0] rel_map;
  logic [WINDOW-1:0] rel_map_next;
  logic [SW-1:0]     total;

  logic [SW-1:0]       diff;
  logic [SW-1:0]       remaining;
  logic                active;
  logic                in_order;
  logic                early;
  logic [D_W-1:0]      run_len;
  logic [D_W-1:0]      step;
  logic [D_W-1:0]      rot;
  logic [WINDOW-1:0]   kept;
  logic [2*WINDOW-1:0] rot_pair;

  always_comb begin
    diff      = item_seq - expected;
    remaining = total - expected;
    active    = expected < total;
    in_order  = active && (item_seq == expected);
    early     = active && (item_seq > expected) && (item_seq < total) &&
                (diff < SW'(WINDOW));

    // First clear slot above the expected one. The scan ends at the expected
    // number's own slot one lap ahead; past that everything is consumed.
    if (rel_map[0]) begin
      run_len = D_W'(WINDOW + 1);
    end else begin
      run_len = D_W'(WINDOW);
    end
    for (int i = WINDOW - 1; i >= 1; i--) begin
      if (!rel_map[i]) begin
        run_len = D_W'(i);
      end
    end

    // The advance stops at the total count.
    if (SW'(run_len) > remaining) begin
      step = remaining[D_W-1:0];
    end else begin
      step = run_len;
    end

    // Clear the slots the advance passes over, then rotate the map.
    kept = rel_map;
    for (int i = 1; i < WINDOW; i++) begin
      if (D_W'(i) < step) begin
        kept[i] = 1'b0;
      end
    end
    if (step > D_W'(WINDOW)) begin
      kept[0] = 1'b0;
    end
    if (step >= D_W'(WINDOW)) begin
      rot = step - D_W'(WINDOW);
    end else begin
      rot = step;
    end
    rot_pair = {kept, kept} >> rot;

    expected_next = expected;
    rel_map_next  = rel_map;
    if (in_order) begin
      expected_next = expected + SW'(step);
      rel_map_next  = rot_pair[WINDOW-1:0];
    end else if (early) begin
      rel_map_next = rel_map | (WINDOW'(1) << diff[IDX_W-1:0]);
    end

    result.ack_number   = AW'({1'b0, expected_next}) - AW'(1);
    result.all_received = expected_next >= total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= '0;
      rel_map  <= '0;
      total    <= swrca_pkg::TOTAL_RESET;
    end else begin
      if (cfg_wr_en) begin
        total <= cfg_wr_data;
      end
      if (item_valid) begin
        expected <= expected_next;
        rel_map  <= rel_map_next;
      end
    end
  end

endmodule

### design/swrca_out_reg.sv
// ----------------------------------------------------------------------------
// swrca_out_reg
// Result register that drives the outgoing stream.
// ----------------------------------------------------------------------------
module swrca_out_reg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  swrca_pkg::result_t                result,
  output logic                              can_load,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swrca_pkg::OUT_TDATA_W-1:0] out_data
);

  localparam int OW = swrca_pkg::OUT_TDATA_W;
  localparam int AW = swrca_pkg::ACK_W;

  swrca_pkg::result_t held;

  assign can_load = !out_valid || out_ready;
  assign out_data = {{(OW - AW - 1){1'b0}}, held.all_received, held.ack_number};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

### design/swrca_checker.sv
// ----------------------------------------------------------------------------
// swrca_checker
// Port-level checks of the sliding-window receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swrca_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_wr_en,
  input logic [swrca_pkg::SEQ_W-1:0]       cfg_wr_data,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [swrca_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [swrca_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int SW = swrca_pkg::SEQ_W;
  localparam int AW = swrca_pkg::ACK_W;

  logic [SW-1:0]        total_seen;
  logic signed [AW-1:0] last_ack;
  logic signed [AW-1:0] ack;
  logic [AW:0]          acked_count;
  logic                 done_expected;
  logic                 unused_in;

  assign ack           = m_axis_tdata[AW-1:0];
  assign acked_count   = {ack[AW-1], ack} + (AW + 1)'(1);
  assign done_expected = acked_count >= (AW + 1)'(total_seen);
  assign unused_in     = s_axis_tvalid ^ (^s_axis_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_seen <= swrca_pkg::TOTAL_RESET;
      last_ack   <= '1;
    end else begin
      if (cfg_wr_en) begin
        total_seen <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        last_ack <= ack;
      end
    end
  end

  `ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")
  `ASSERT_ANY(a_reset_empty, rst |=> !m_axis_tvalid, "result valid right after reset")
  `ASSERT_RUN(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready || unused_in != unused_in, "input stalled with empty output")
  `ASSERT_RUN(a_ack_monotonic, m_axis_tvalid && m_axis_tready |-> ack >= last_ack, "cumulative ack moved backward")
  `ASSERT_RUN(a_done_flag, m_axis_tvalid |-> m_axis_tdata[AW] == done_expected, "completion flag disagrees with ack and total")

endmodule

bind sliding_window_receiver_cumulative_ack_unit swrca_checker u_swrca_checker (.*);
